// ----- rtl/core/pfm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pfm_pkg;

	// Field widths
	localparam int unsigned TICK_RATE_W = 20;
	localparam int unsigned FREQ_W      = 17;
	localparam int unsigned DIGIT_W     = 6;
	localparam int unsigned NUM_DIGITS  = 5;
	localparam int unsigned BCD_W       = 4 * NUM_DIGITS;

	// Default and reset values
	localparam int unsigned COUNT_BITS_DEFAULT = 16;
	localparam int unsigned DIGIT_COUNT        = 5;
	localparam logic [TICK_RATE_W-1:0] TICK_RATE_RESET = TICK_RATE_W'(250000);
	localparam logic [DIGIT_W-1:0] ASCII_ZERO = DIGIT_W'(48);

	// Queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// Step counter for the divider and the binary to BCD converter
	localparam int unsigned STEP_W = $clog2(TICK_RATE_W);

	// Register map
	localparam int unsigned PADDR_W = 3;
	localparam logic [PADDR_W-1:0] REG_TICK_RATE_ADDR = PADDR_W'(0);

	// Largest value that the used number of decimal digits can show
	function automatic int unsigned freq_limit(input int unsigned digits);
		int unsigned d;
		int unsigned lim;
		d = digits;
		lim = 1;
		if (d < 1) begin
			d = 1;
		end
		if (d > NUM_DIGITS) begin
			d = NUM_DIGITS;
		end
		for (int unsigned i = 0; i < NUM_DIGITS; i++) begin
			if (i < d) begin
				lim = lim * 10;
			end
		end
		return lim - 1;
	endfunction

	localparam logic [TICK_RATE_W-1:0] FREQ_LIMIT = TICK_RATE_W'(freq_limit(DIGIT_COUNT));

	// Back end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_SAT,
		BK_CONV,
		BK_OUT
	} bk_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/pfm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfm_front #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                tick,
	input  wire logic                pin_level,
	output logic                     push,
	output logic [COUNT_BITS-1:0]    push_count,
	output logic                     push_sat
);
	import pfm_pkg::*;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic                  prev_level_q;
	logic                  measuring_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  sat_q;

	logic                  rise;
	logic                  at_max;
	logic [COUNT_BITS-1:0] count_next;
	logic                  sat_next;

	// Detect the rising edge and advance the saturating period count
	always_comb begin
		rise       = !prev_level_q && pin_level;
		at_max     = (count_q == COUNT_MAX);
		count_next = at_max ? COUNT_MAX : count_q + COUNT_BITS'(1);
		sat_next   = sat_q || at_max;
		push       = tick && measuring_q && rise;
		push_count = count_next;
		push_sat   = sat_next;
	end

	// Track the measurement on every tick transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b1;
			measuring_q  <= 1'b0;
			count_q      <= '0;
			sat_q        <= 1'b0;
		end else if (tick) begin
			prev_level_q <= pin_level;
			if (measuring_q) begin
				count_q <= count_next;
				sat_q   <= sat_next;
				if (rise) begin
					measuring_q <= 1'b0;
				end
			end else if (rise) begin
				measuring_q <= 1'b1;
				count_q     <= '0;
				sat_q       <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/pfm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfm_queue #(
	parameter int unsigned WIDTH = 17,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  full,
	output logic                  empty
);
	import pfm_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign full     = (fill_q == CNT_W'(DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	// Hold entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/pfm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfm_back #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [pfm_pkg::TICK_RATE_W-1:0]   tick_rate,
	input  wire logic                              q_empty,
	input  wire logic [COUNT_BITS-1:0]             q_count,
	input  wire logic                              q_sat,
	output logic                                   q_pop,
	output logic                                   res_valid,
	input  wire logic                              res_ready,
	output logic [pfm_pkg::FREQ_W-1:0]             res_freq,
	output logic [pfm_pkg::BCD_W-1:0]              res_bcd,
	output logic                                   res_over,
	output logic                                   res_slow
);
	import pfm_pkg::*;

	bk_state_t state_q;
	bk_state_t state_d;

	logic [COUNT_BITS-1:0]  divisor_q;
	logic [COUNT_BITS-1:0]  rem_q;
	logic [TICK_RATE_W-1:0] quo_q;
	logic                   zero_q;
	logic                   sat_q;
	logic                   over_q;
	logic [FREQ_W-1:0]      freq_q;
	logic [FREQ_W-1:0]      bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [STEP_W-1:0]      step_q;

	logic [COUNT_BITS:0]    trial;
	logic [COUNT_BITS:0]    diff;
	logic                   fits;
	logic [BCD_W-1:0]       bcd_adj;
	logic                   div_last;
	logic                   conv_last;

	// One restoring division step
	always_comb begin
		trial = {rem_q, quo_q[TICK_RATE_W-1]};
		diff  = trial - {1'b0, divisor_q};
		fits  = (trial >= {1'b0, divisor_q});
	end

	// Add three to every BCD digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
		end
	end

	assign div_last  = (step_q == STEP_W'(TICK_RATE_W - 1));
	assign conv_last = (step_q == STEP_W'(FREQ_W - 1));

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Select the next state and the handshake outputs
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_last) begin
					state_d = BK_SAT;
				end
			end
			BK_SAT: begin
				state_d = BK_CONV;
			end
			BK_CONV: begin
				if (conv_last) begin
					state_d = BK_OUT;
				end
			end
			BK_OUT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Divide, saturate and convert to decimal
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				divisor_q <= q_count;
				zero_q    <= (q_count == '0);
				sat_q     <= q_sat;
				rem_q     <= '0;
				quo_q     <= tick_rate;
				step_q    <= '0;
			end
			BK_DIV: begin
				rem_q  <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
				quo_q  <= {quo_q[TICK_RATE_W-2:0], fits};
				step_q <= div_last ? '0 : step_q + STEP_W'(1);
			end
			BK_SAT: begin
				if (zero_q || (quo_q > FREQ_LIMIT)) begin
					freq_q <= FREQ_LIMIT[FREQ_W-1:0];
					bin_q  <= FREQ_LIMIT[FREQ_W-1:0];
					over_q <= 1'b1;
				end else begin
					freq_q <= quo_q[FREQ_W-1:0];
					bin_q  <= quo_q[FREQ_W-1:0];
					over_q <= 1'b0;
				end
				bcd_q <= '0;
			end
			BK_CONV: begin
				bcd_q  <= {bcd_adj[BCD_W-2:0], bin_q[FREQ_W-1]};
				bin_q  <= {bin_q[FREQ_W-2:0], 1'b0};
				step_q <= conv_last ? '0 : step_q + STEP_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign res_freq = freq_q;
	assign res_bcd  = bcd_q;
	assign res_over = over_q;
	assign res_slow = sat_q;

endmodule

`default_nettype wire

// ----- rtl/core/period_frequency_meter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Reciprocal frequency meter. Each slave transaction is one timer tick with the sampled
// pin level in s_tdata[0]; ticks are taken one per cycle while the two-entry result queue
// has room. A rising edge starts a period count, the next rising edge closes it and queues
// the count; the back end then divides tick_rate by it bit-serially, saturates and converts
// to BCD by shift-and-add-three; the result is held in an output register until taken.
// s_tready drops only when two closed measurements are still waiting. tick_rate is written
// at byte address 0 of the APB port and must only be changed while the meter is idle.
module period_frequency_meter #(
	parameter int unsigned COUNT_BITS = pfm_pkg::COUNT_BITS_DEFAULT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// APB configuration
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pfm_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	// Tick stream
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [7:0]                  s_tdata,   // [0] pin_level
	// Result stream
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [47:0]                      m_tdata,   // [16:0] frequency, [22:17] ten
	                                                    // thousands, [28:23] thousands,
	                                                    // [34:29] hundreds, [40:35] tens,
	                                                    // [46:41] ones digit (ASCII)
	output logic [1:0]                       m_tuser    // [0] over_range, [1] too_slow
);
	import pfm_pkg::*;

	logic [TICK_RATE_W-1:0] tick_rate_q;
	logic                   cfg_write;

	logic                   tick;
	logic                   push;
	logic [COUNT_BITS-1:0]  push_count;
	logic                   push_sat;
	logic                   pop;
	logic [COUNT_BITS:0]    pop_data;
	logic                   q_full;
	logic                   q_empty;

	logic [FREQ_W-1:0]      res_freq;
	logic [BCD_W-1:0]       res_bcd;
	logic                   res_over;
	logic                   res_slow;

	// Write and read the tick rate register
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_TICK_RATE_ADDR);
	assign prdata    = (paddr == REG_TICK_RATE_ADDR) ? 32'(tick_rate_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= TICK_RATE_RESET;
		end else if (cfg_write) begin
			tick_rate_q <= pwdata[TICK_RATE_W-1:0];
		end
	end

	// Accept ticks while the queue has room
	assign s_tready = !q_full;
	assign tick     = s_tvalid && s_tready;

	pfm_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.pin_level  (s_tdata[0]),
		.push       (push),
		.push_count (push_count),
		.push_sat   (push_sat)
	);

	pfm_queue #(
		.WIDTH (COUNT_BITS + 1),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_sat, push_count}),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	pfm_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_rate (tick_rate_q),
		.q_empty   (q_empty),
		.q_count   (pop_data[COUNT_BITS-1:0]),
		.q_sat     (pop_data[COUNT_BITS]),
		.q_pop     (pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_freq  (res_freq),
		.res_bcd   (res_bcd),
		.res_over  (res_over),
		.res_slow  (res_slow)
	);

	// Pack the result, most significant digit first after the frequency
	always_comb begin
		m_tdata = '0;
		m_tdata[FREQ_W-1:0] = res_freq;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			m_tdata[FREQ_W + DIGIT_W*i +: DIGIT_W] =
				ASCII_ZERO + {2'b00, res_bcd[4*(NUM_DIGITS-1-i) +: 4]};
		end
		m_tuser = {res_slow, res_over};
	end

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import pfm_pkg::*;

	localparam int unsigned CLK_HALF     = 5;
	localparam int unsigned CNT_W        = COUNT_BITS_DEFAULT;
	localparam logic [16:0] FREQ_MAX     = 17'd99999;
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned STALL_LIMIT  = 4000;
	localparam int unsigned RANDOM_TICKS = 1800;
	localparam int unsigned IDLE_PCT     = 22;
	localparam int unsigned QUIET_FROM   = 700;
	localparam int unsigned QUIET_TO     = 1100;

	typedef struct packed {
		logic [16:0]     freq;
		logic [4:0][5:0] digits;      // [4] ten thousands ... [0] ones
		logic            over_range;
		logic            too_slow;
	} freq_result_t;

	typedef struct packed {
		logic [TICK_RATE_W-1:0] rate;
		logic [17:0]            span;   // period in ticks
		logic                   typed;
		logic [16:0]            freq;
		logic                   over_range;
		logic                   too_slow;
	} meter_row_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [PADDR_W-1:0]  paddr    = '0;
	logic [31:0]         pwdata   = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata  = '0;   // [0] pin_level
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [47:0]         m_tdata;         // [16:0] frequency, [22:17] .. [46:41] digits
	logic [1:0]          m_tuser;         // [0] over_range, [1] too_slow

	// Predictor state
	logic                   prev_lvl      = 1'b1;
	logic                   measuring     = 1'b0;
	logic [CNT_W-1:0]       period_cnt    = '0;
	logic                   cnt_sat       = 1'b0;
	logic [TICK_RATE_W-1:0] tick_rate_cfg = TICK_RATE_RESET;

	freq_result_t freq_results_q[$];
	int unsigned  errors       = 0;
	int unsigned  ticks_sent   = 0;
	int unsigned  stall_cycles = 0;
	bit           quiet        = 1'b0;

	period_frequency_meter dut (.*);

	always #CLK_HALF clk = ~clk;

	function automatic logic [4:0][5:0] ascii_digits(input logic [16:0] f);
		logic [4:0][5:0] d;
		int unsigned div;
		div = 10000;
		for (int k = 4; k >= 0; k--) begin
			d[k] = 6'((f / div) % 10) + ASCII_ZERO;
			div = div / 10;
		end
		return d;
	endfunction

	task automatic report(input string what, input longint unsigned exp_v,
			input longint unsigned act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t %s: expected %0d, got %0d", $time, what, exp_v, act_v);
		end
	endtask

	// Advance the meter model by one accepted tick
	task automatic meter_step(input logic lvl);
		logic                   rise;
		logic [TICK_RATE_W-1:0] quot;
		freq_result_t           r;
		rise = !prev_lvl && lvl;
		prev_lvl = lvl;
		if (measuring) begin
			if (period_cnt == '1) begin
				cnt_sat = 1'b1;
			end else begin
				period_cnt++;
			end
			if (rise) begin
				quot = tick_rate_cfg / period_cnt;
				r.over_range = quot > FREQ_MAX;
				if (r.over_range) begin
					quot = FREQ_MAX;
				end
				r.freq = quot[16:0];
				r.digits = ascii_digits(r.freq);
				r.too_slow = cnt_sat;
				freq_results_q.push_back(r);
				measuring = 1'b0;
			end
		end else if (rise) begin
			measuring = 1'b1;
			period_cnt = '0;
			cnt_sat = 1'b0;
		end
	endtask

	// Present one tick, hold it until taken, then predict
	task automatic send_tick(input logic lvl);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, lvl};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		ticks_sent++;
		meter_step(lvl);
	endtask

	// Idle the tick stream until every pending result is out and the back end is quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (freq_results_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= REG_TICK_RATE_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_tick_rate(input logic [TICK_RATE_W-1:0] rate);
		logic [31:0] rd;
		drain();
		apb_xfer(1'b1, 32'(rate), rd);
		tick_rate_cfg = rate;
		apb_xfer(1'b0, '0, rd);
		report("tick_rate readback", rate, rd);
	endtask

	// One well-formed measurement: fresh edge, high run, low run, closing edge
	task automatic run_period(input int unsigned span);
		int unsigned hold;
		hold = $urandom_range(span - 2);
		repeat ($urandom_range(1, 3)) send_tick(1'b0);
		send_tick(1'b1);
		for (int unsigned t = 1; t < span; t++) begin
			send_tick(t <= hold);
		end
		send_tick(1'b1);
	endtask

	// Random stall on the result side
	always @(posedge clk) begin
		m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		freq_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (freq_results_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result: freq %0d", $time, m_tdata[16:0]);
			end else begin
				want = freq_results_q.pop_front();
				report("frequency", want.freq, m_tdata[16:0]);
				report("digit_ten_thousands", want.digits[4], m_tdata[22:17]);
				report("digit_thousands", want.digits[3], m_tdata[28:23]);
				report("digit_hundreds", want.digits[2], m_tdata[34:29]);
				report("digit_tens", want.digits[1], m_tdata[40:35]);
				report("digit_ones", want.digits[0], m_tdata[46:41]);
				report("over_range", want.over_range, m_tuser[0]);
				report("too_slow", want.too_slow, m_tuser[1]);
			end
		end
	end

	// Abort when no transaction completes for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		meter_row_t  plan [17];
		logic [31:0] rd;
		int unsigned pick;
		int unsigned span;
		logic [TICK_RATE_W-1:0] rate;

		// rate, period, typed, freq, over_range, too_slow
		plan = '{
			'{20'd250000, 18'd2, 1'b1, 17'd99999, 1'b1, 1'b0},
			'{20'd250000, 18'd3, 1'b0, 17'd0, 1'b0, 1'b0},
			'{20'd250000, 18'd5, 1'b0, 17'd0, 1'b0, 1'b0},
			'{20'd199998, 18'd2, 1'b1, 17'd99999, 1'b0, 1'b0},
			'{20'd200000, 18'd2, 1'b1, 17'd99999, 1'b1, 1'b0},
			'{20'd0, 18'd2, 1'b1, 17'd0, 1'b0, 1'b0},
			'{20'd0, 18'd65536, 1'b1, 17'd0, 1'b0, 1'b1},
			'{20'd1, 18'd2, 1'b1, 17'd0, 1'b0, 1'b0},
			'{20'd1, 18'd7, 1'b0, 17'd0, 1'b0, 1'b0},
			'{20'hFFFFF, 18'd11, 1'b0, 17'd0, 1'b0, 1'b0},
			'{20'hFFFFF, 18'd65535, 1'b1, 17'd16, 1'b0, 1'b0},
			'{20'hFFFFF, 18'd65536, 1'b1, 17'd16, 1'b0, 1'b1},
			'{20'd1000000, 18'd70000, 1'b1, 17'd15, 1'b0, 1'b1},
			'{20'd1000000, 18'd10, 1'b1, 17'd99999, 1'b1, 1'b0},
			'{20'd1000000, 18'd11, 1'b0, 17'd0, 1'b0, 1'b0},
			'{20'd123456, 18'd4, 1'b0, 17'd0, 1'b0, 1'b0},
			'{20'd99999, 18'd2, 1'b0, 17'd0, 1'b0, 1'b0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Check the reset value of tick_rate
		apb_xfer(1'b0, '0, rd);
		report("tick_rate after reset", TICK_RATE_RESET, rd);

		// A high level right after reset is no edge
		repeat (3) send_tick(1'b1);

		// Directed measurements
		foreach (plan[i]) begin
			if (plan[i].rate != tick_rate_cfg) begin
				set_tick_rate(plan[i].rate);
			end
			run_period(plan[i].span);
			if (plan[i].typed) begin
				freq_results_q[freq_results_q.size() - 1] = '{plan[i].freq,
					ascii_digits(plan[i].freq), plan[i].over_range, plan[i].too_slow};
			end
		end

		// Random mix of measurements, rate changes and pin noise
		ticks_sent = 0;
		while (ticks_sent < RANDOM_TICKS) begin
			quiet = (ticks_sent >= QUIET_FROM) && (ticks_sent < QUIET_TO);
			if (measuring) begin
				send_tick(1'b0);
				send_tick(1'b1);
			end
			pick = $urandom_range(99);
			if (pick < 6) begin
				case ($urandom_range(7))
					0: rate = '0;
					1: rate = 20'd1;
					2: rate = 20'hFFFFF;
					3: rate = 20'd1000000;
					4, 5: rate = TICK_RATE_W'($urandom_range(1, 1000000));
					default: rate = TICK_RATE_W'($urandom_range(1, 200000));
				endcase
				set_tick_rate(rate);
			end else if (pick < 22) begin
				repeat ($urandom_range(1, 24)) send_tick(1'($urandom_range(1)));
			end else begin
				pick = $urandom_range(99);
				if (pick < 75) begin
					span = $urandom_range(2, 12);
				end else if (pick < 97) begin
					span = $urandom_range(13, 120);
				end else begin
					span = $urandom_range(121, 2000);
				end
				run_period(span);
			end
		end
		quiet = 1'b0;

		drain();
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
